// ===== rtl/vector_euclid_manhattan_distance_unit_macros.svh =====
// assertion macros for the vector distance unit
// needs clk and rst in the scope where a macro is used
`ifndef VECTOR_EUCLID_MANHATTAN_DISTANCE_UNIT_MACROS_SVH
`define VECTOR_EUCLID_MANHATTAN_DISTANCE_UNIT_MACROS_SVH

// same-cycle implication
`define VEMD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define VEMD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/vemd_pkg.sv =====
// shared types and constants of the vector distance unit
// no dependencies
package vemd_pkg;

  // result field widths
  localparam int EUCLID_W    = 22;
  localparam int MANHATTAN_W = 28;

  localparam logic [EUCLID_W-1:0]    EUCLID_MAX    = '1;
  localparam logic [MANHATTAN_W-1:0] MANHATTAN_MAX = '1;

  // controller states
  typedef enum logic [1:0] {
    ST_ACCUM,
    ST_DRAIN,
    ST_ROOT,
    ST_RESULT
  } vemd_state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic root_init;
    logic root_step;
    logic out_load;
  } vemd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic fin_ready;
    logic root_done;
  } vemd_stat_t;

endpackage

// ===== rtl/vector_euclid_manhattan_distance_unit.sv =====
// Streaming Euclidean and Manhattan distance between two vectors. Each input beat
// carries one element pair and a last mark; beats are taken one per cycle while a
// vector is streaming. The beat marked last closes the vector: it passes the
// three-stage difference/square/accumulate pipeline, then an iterative square root
// produces one root bit per cycle (SAMPLE_WIDTH + clog2(MAX_LEN)/2 steps, rounded up;
// 22 steps at the defaults), and the result beat is offered once the root is loaded
// into the output registers. No new element is taken from the last element until its
// result beat has been delivered. Past MAX_LEN elements both sums saturate and
// too_long is set. No clearing pass is needed after reset.
`include "vector_euclid_manhattan_distance_unit_macros.svh"

module vector_euclid_manhattan_distance_unit #(
  parameter int MAX_LEN      = 4096,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               elem_valid,
  output logic                               elem_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]     elem_a,
  input  logic signed [SAMPLE_WIDTH-1:0]     elem_b,
  input  logic                               last_elem,
  output logic                               dist_valid,
  input  logic                               dist_ready,
  output logic [vemd_pkg::EUCLID_W-1:0]      euclid_dist,
  output logic [vemd_pkg::MANHATTAN_W-1:0]   manhattan_dist,
  output logic                               too_long
);

  vemd_pkg::vemd_cmd_t  cmd;
  vemd_pkg::vemd_stat_t stat;

  // sequencing
  vemd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .elem_valid (elem_valid),
    .last_elem  (last_elem),
    .elem_ready (elem_ready),
    .dist_valid (dist_valid),
    .dist_ready (dist_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // arithmetic
  vemd_datapath #(
    .MAX_LEN      (MAX_LEN),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .elem_a         (elem_a),
    .elem_b         (elem_b),
    .last_elem      (last_elem),
    .euclid_dist    (euclid_dist),
    .manhattan_dist (manhattan_dist),
    .too_long       (too_long)
  );

  // checks
  `VEMD_ASSERT_NOW(a_no_input_with_result, dist_valid, !elem_ready,
    "input taken while a result beat is pending")
  `VEMD_ASSERT_NEXT(a_last_blocks_input, elem_valid && elem_ready && last_elem,
    !elem_ready && !dist_valid, "input not blocked after last element")
  `VEMD_ASSERT_NEXT(a_result_frees_input, dist_valid && dist_ready,
    elem_ready && !dist_valid, "input not reopened after result beat")

endmodule

// ===== rtl/vemd_isqrt.sv =====
// iterative floor square root, one result bit per cycle while step is held high
// no package dependencies
module vemd_isqrt #(
  parameter int IN_W = 46
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                init,
  input  logic                step,
  input  logic [IN_W-1:0]     radicand,
  output logic [IN_W/2-1:0]   root,
  output logic                done
);

  localparam int RT_W  = IN_W / 2;
  localparam int CNT_W = $clog2(RT_W + 1);

  logic [IN_W-1:0]  x;
  logic [RT_W:0]    rem;
  logic [CNT_W-1:0] cnt;

  logic [RT_W+2:0] rem_t;
  logic [RT_W+2:0] trial;
  logic [RT_W+2:0] diff;
  logic            ge;

  // trial subtraction of 4*root+1 from the shifted remainder
  always_comb begin
    rem_t = {rem, x[IN_W-1 -: 2]};
    trial = {1'b0, root, 2'b01};
    diff  = rem_t - trial;
    ge    = rem_t >= trial;
  end

  assign done = cnt == CNT_W'(RT_W);

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (init) begin
      cnt <= '0;
    end else if (step) begin
      cnt <= cnt + 1'b1;
    end
  end

  // remainder, partial root and radicand shift
  always_ff @(posedge clk) begin
    if (init) begin
      x    <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (step) begin
      x    <= {x[IN_W-3:0], 2'b00};
      rem  <= ge ? diff[RT_W:0] : rem_t[RT_W:0];
      root <= {root[RT_W-2:0], ge};
    end
  end

endmodule

// ===== rtl/vemd_datapath.sv =====
// difference, square and accumulate pipeline plus final root and output registers
// depends on vemd_pkg and vemd_isqrt
module vemd_datapath #(
  parameter int MAX_LEN      = 4096,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  vemd_pkg::vemd_cmd_t                    cmd,
  output vemd_pkg::vemd_stat_t                   stat,
  input  logic signed [SAMPLE_WIDTH-1:0]         elem_a,
  input  logic signed [SAMPLE_WIDTH-1:0]         elem_b,
  input  logic                                   last_elem,
  output logic [vemd_pkg::EUCLID_W-1:0]          euclid_dist,
  output logic [vemd_pkg::MANHATTAN_W-1:0]       manhattan_dist,
  output logic                                   too_long
);

  localparam int SW    = SAMPLE_WIDTH;
  localparam int LG    = $clog2(MAX_LEN);
  localparam int SQ_W  = 2 * SW + LG;
  localparam int AB_W  = SW + LG;
  localparam int CNT_W = $clog2(MAX_LEN + 1);
  localparam int SQ_E  = 2 * ((SQ_W + 1) / 2);
  localparam int RT_W  = SQ_E / 2;
  localparam int EC_W  = (RT_W > vemd_pkg::EUCLID_W) ? RT_W : vemd_pkg::EUCLID_W;
  localparam int MC_W  = (AB_W > vemd_pkg::MANHATTAN_W) ? AB_W : vemd_pkg::MANHATTAN_W;

  localparam logic [SW-1:0]    DMAX   = '1;
  localparam logic [SQ_W-1:0]  CAP_SQ = SQ_W'(MAX_LEN) * SQ_W'(DMAX) * SQ_W'(DMAX);
  localparam logic [AB_W-1:0]  CAP_AB = AB_W'(MAX_LEN) * AB_W'(DMAX);

  // stage 1: absolute difference
  logic signed [SW:0] diff;
  logic [SW-1:0]      abs_diff;
  logic               s1_valid;
  logic               s1_last;
  logic [SW-1:0]      s1_ad;

  always_comb begin
    diff     = {elem_a[SW-1], elem_a} - {elem_b[SW-1], elem_b};
    abs_diff = diff[SW] ? SW'(-diff) : diff[SW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.accept;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      s1_ad   <= abs_diff;
      s1_last <= last_elem;
    end
  end

  // stage 2: square
  logic              s2_valid;
  logic              s2_last;
  logic [SW-1:0]     s2_ad;
  logic [2*SW-1:0]   s2_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      s2_ad   <= s1_ad;
      s2_last <= s1_last;
      s2_sq   <= s1_ad * s1_ad;
    end
  end

  // stage 3: saturating accumulate and element count
  logic [SQ_W-1:0]  sum_squares;
  logic [AB_W-1:0]  sum_absolute;
  logic [CNT_W-1:0] element_count;
  logic             overflow_seen;
  logic             fin_ready;

  logic [SQ_W:0]    sq_wide;
  logic [AB_W:0]    ab_wide;
  logic [SQ_W-1:0]  sq_sat;
  logic [AB_W-1:0]  ab_sat;
  logic             at_max;

  always_comb begin
    sq_wide = {1'b0, sum_squares} + (SQ_W + 1)'(s2_sq);
    ab_wide = {1'b0, sum_absolute} + (AB_W + 1)'(s2_ad);
    sq_sat  = (sq_wide > {1'b0, CAP_SQ}) ? CAP_SQ : sq_wide[SQ_W-1:0];
    ab_sat  = (ab_wide > {1'b0, CAP_AB}) ? CAP_AB : ab_wide[AB_W-1:0];
    at_max  = element_count == CNT_W'(MAX_LEN);
  end

  logic [SQ_W-1:0] fin_sq;
  logic [AB_W-1:0] fin_abs;
  logic            fin_ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_squares    <= '0;
      sum_absolute   <= '0;
      element_count  <= '0;
      overflow_seen  <= 1'b0;
      fin_ready      <= 1'b0;
    end else begin
      fin_ready <= s2_valid && s2_last;
      if (s2_valid) begin
        if (s2_last) begin
          sum_squares   <= '0;
          sum_absolute  <= '0;
          element_count <= '0;
          overflow_seen <= 1'b0;
        end else begin
          sum_squares   <= sq_sat;
          sum_absolute  <= ab_sat;
          if (at_max) begin
            overflow_seen <= 1'b1;
          end else begin
            element_count <= element_count + 1'b1;
          end
        end
      end
    end
  end

  // final sums of a finished vector pair
  always_ff @(posedge clk) begin
    if (s2_valid && s2_last) begin
      fin_sq  <= sq_sat;
      fin_abs <= ab_sat;
      fin_ovf <= overflow_seen || at_max;
    end
  end

  // square root of the final squared sum
  logic [RT_W-1:0] root;
  logic            root_done;

  vemd_isqrt #(
    .IN_W(SQ_E)
  ) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .init     (cmd.root_init),
    .step     (cmd.root_step),
    .radicand (SQ_E'(fin_sq)),
    .root     (root),
    .done     (root_done)
  );

  assign stat = '{fin_ready: fin_ready, root_done: root_done};

  // clamp to field widths and hold the result beat
  logic [EC_W-1:0] root_ext;
  logic [MC_W-1:0] abs_ext;

  always_comb begin
    root_ext = EC_W'(root);
    abs_ext  = MC_W'(fin_abs);
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      euclid_dist    <= (root_ext > EC_W'(vemd_pkg::EUCLID_MAX)) ?
                        vemd_pkg::EUCLID_MAX : root_ext[vemd_pkg::EUCLID_W-1:0];
      manhattan_dist <= (abs_ext > MC_W'(vemd_pkg::MANHATTAN_MAX)) ?
                        vemd_pkg::MANHATTAN_MAX : abs_ext[vemd_pkg::MANHATTAN_W-1:0];
      too_long       <= fin_ovf;
    end
  end

endmodule

// ===== rtl/vemd_ctrl.sv =====
// control state machine: accumulate, drain, root, result handoff
// depends on vemd_pkg
module vemd_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 elem_valid,
  input  logic                 last_elem,
  output logic                 elem_ready,
  output logic                 dist_valid,
  input  logic                 dist_ready,
  input  vemd_pkg::vemd_stat_t stat,
  output vemd_pkg::vemd_cmd_t  cmd
);

  vemd_pkg::vemd_state_t state;
  vemd_pkg::vemd_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vemd_pkg::ST_ACCUM;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      vemd_pkg::ST_ACCUM: begin
        if (elem_valid && last_elem) state_next = vemd_pkg::ST_DRAIN;
      end
      vemd_pkg::ST_DRAIN: begin
        if (stat.fin_ready) state_next = vemd_pkg::ST_ROOT;
      end
      vemd_pkg::ST_ROOT: begin
        if (stat.root_done) state_next = vemd_pkg::ST_RESULT;
      end
      vemd_pkg::ST_RESULT: begin
        if (dist_ready) state_next = vemd_pkg::ST_ACCUM;
      end
      default: begin
        state_next = vemd_pkg::ST_ACCUM;
      end
    endcase
  end

  // outputs and datapath commands
  always_comb begin
    elem_ready    = 1'b0;
    dist_valid    = 1'b0;
    cmd           = '0;
    case (state)
      vemd_pkg::ST_ACCUM: begin
        elem_ready = 1'b1;
        cmd.accept = elem_valid;
      end
      vemd_pkg::ST_DRAIN: begin
        cmd.root_init = stat.fin_ready;
      end
      vemd_pkg::ST_ROOT: begin
        cmd.root_step = !stat.root_done;
        cmd.out_load  = stat.root_done;
      end
      vemd_pkg::ST_RESULT: begin
        dist_valid = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule
